@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. All of them sample on clk and are
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/ptt_pkg.sv @@
`default_nettype none
package ptt_pkg;
	localparam int TABLE_ENTRIES = 32;
	localparam int TIME_BITS     = 40;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = 48;
	localparam int KEY_W         = ADDR_W + 2;
	localparam int SLOT_W        = 5;
	localparam int CNT_W         = 6;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_RECENT_WINDOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_WINDOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD  = 3'd4;

	localparam logic [CFG_W-1:0] RESET_RECENT_WINDOW   = 16'd5000;
	localparam logic [CFG_W-1:0] RESET_STALE_WINDOW    = 16'd15000;
	localparam logic [CFG_W-1:0] RESET_REPORT_INTERVAL = 16'd1000;
	localparam logic [CFG_W-1:0] RESET_CHANGE_INTERVAL = 16'd250;
	localparam logic [7:0]       RESET_RSSI_THRESHOLD  = 8'd8;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_CENSUS  = 1'b1;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_TRACKER = 2'd1;
	localparam logic [1:0] KIND_BEACON  = 2'd2;
	localparam logic [1:0] KIND_UPDATE  = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [1:0]           kind;
		logic                 dfu;
		logic [7:0]           rssi;
		logic [TIME_BITS-1:0] last_seen;
		logic [TIME_BITS-1:0] last_report;
		logic                 reported;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;
endpackage
`default_nettype wire

@@ src/ptt_ram.sv @@
`default_nettype none
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ src/peer_tracking_table_core.sv @@
// Peer tracking table.
// Input channel (in_valid / in_stall) carries one observation or census per
// beat; output channel (out_valid / out_stall) returns exactly one result
// beat per input beat, in order. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data), used while the block is idle (the block does not enforce this).
// The table lives in one single-port-read RAM of TABLE_ENTRIES records plus
// a flip-flop valid bit per entry. Every census and every observation that
// is not dropped walks the RAM one entry per cycle; a dropped observation
// needs no walk. One item is worked on at a time; in_stall is high until
// its result has been placed in the output register. A new beat is accepted
// while that result still waits.
// Reset clears all valid bits at once and restores the register defaults;
// no clearing pass over the RAM is needed.
// While out_stall holds the output beat, the block finishes the walk of a
// following item and then waits with its write-back until the beat is taken.
`default_nettype none
`include "assert_macros.svh"
module peer_tracking_table_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ptt_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           op,
	input  wire logic [ptt_pkg::ADDR_W-1:0]     address,
	input  wire logic [1:0]                     address_type,
	input  wire logic [ptt_pkg::TIME_BITS-1:0]  now_ms,
	input  wire logic signed [7:0]              rssi,
	input  wire logic [1:0]                     adv_kind,
	input  wire logic                           name_only_kind,
	input  wire logic                           name_present,
	input  wire logic                           has_dfu,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                dropped,
	output logic [ptt_pkg::SLOT_W-1:0]          slot,
	output logic                                changed,
	output logic                                report,
	output logic [1:0]                          report_kind,
	output logic signed [7:0]                   report_rssi,
	output logic [ptt_pkg::CNT_W-1:0]           tag_count,
	output logic [ptt_pkg::CNT_W-1:0]           anchor_count,
	output logic [ptt_pkg::CNT_W-1:0]           dfu_count,
	output logic [ptt_pkg::CNT_W-1:0]           unknown_count,
	output logic [ptt_pkg::CNT_W-1:0]           stale_count,
	output logic [ptt_pkg::CNT_W-1:0]           recent_count
);
	localparam int TB = ptt_pkg::TIME_BITS;
	localparam int IW = ptt_pkg::IDX_W;
	localparam int CW = ptt_pkg::CNT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(ptt_pkg::TABLE_ENTRIES - 1);

	function automatic logic [TB-1:0] age_of(logic [TB-1:0] later, logic [TB-1:0] earlier);
		return (later >= earlier) ? (later - earlier) : '0;
	endfunction

	function automatic logic [TB-1:0] win_ext(logic [ptt_pkg::CFG_W-1:0] w);
		return {{(TB - ptt_pkg::CFG_W){1'b0}}, w};
	endfunction

	function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [ptt_pkg::SLOT_W-1:0] slot_of(logic [IW-1:0] idx);
		logic [IW+ptt_pkg::SLOT_W-1:0] wide;
		wide = {{ptt_pkg::SLOT_W{1'b0}}, idx};
		return wide[ptt_pkg::SLOT_W-1:0];
	endfunction

	// Configuration registers.
	logic [ptt_pkg::CFG_W-1:0] recent_window_q, stale_window_q;
	logic [ptt_pkg::CFG_W-1:0] report_interval_q, change_interval_q;
	logic [7:0]                rssi_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_window_q   <= ptt_pkg::RESET_RECENT_WINDOW;
			stale_window_q    <= ptt_pkg::RESET_STALE_WINDOW;
			report_interval_q <= ptt_pkg::RESET_REPORT_INTERVAL;
			change_interval_q <= ptt_pkg::RESET_CHANGE_INTERVAL;
			rssi_threshold_q  <= ptt_pkg::RESET_RSSI_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				ptt_pkg::CFG_RECENT_WINDOW:   recent_window_q   <= cfg_data;
				ptt_pkg::CFG_STALE_WINDOW:    stale_window_q    <= cfg_data;
				ptt_pkg::CFG_REPORT_INTERVAL: report_interval_q <= cfg_data;
				ptt_pkg::CFG_CHANGE_INTERVAL: change_interval_q <= cfg_data;
				ptt_pkg::CFG_RSSI_THRESHOLD:  rssi_threshold_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Control.
	ptt_pkg::state_t state_q, state_d;
	logic accept, fire, ram_re, ram_we;
	logic drop_in;
	logic issuing_q;
	logic [IW-1:0] issue_q;
	logic rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	assign drop_in = (op == ptt_pkg::OP_OBSERVE) && (adv_kind == ptt_pkg::KIND_NONE)
		&& !name_present && !has_dfu;

	// Item registers.
	logic                    census_q, drop_q;
	logic [ptt_pkg::KEY_W-1:0] key_q;
	logic [TB-1:0]           now_q;
	logic [7:0]              rssi_q;
	logic [1:0]              kind_q;
	logic                    from_name_q, has_dfu_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = drop_in ? ptt_pkg::ST_FINISH : ptt_pkg::ST_SCAN;
				end
			end
			ptt_pkg::ST_SCAN: begin
				if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
					state_d = ptt_pkg::ST_FINISH;
				end
			end
			ptt_pkg::ST_FINISH: begin
				if (!out_valid || !out_stall) begin
					state_d = ptt_pkg::ST_IDLE;
				end
			end
			default: state_d = ptt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ptt_pkg::ST_IDLE);
		accept   = in_valid && (state_q == ptt_pkg::ST_IDLE);
		ram_re   = (state_q == ptt_pkg::ST_SCAN) && issuing_q;
		fire     = (state_q == ptt_pkg::ST_FINISH) && (!out_valid || !out_stall);
		ram_we   = fire && !census_q && !drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptt_pkg::ST_IDLE;
			issuing_q <= 1'b0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			rd_idx_s1 <= issue_q;
			if (accept) begin
				issuing_q <= !drop_in;
				issue_q   <= '0;
			end else if (ram_re) begin
				if (issue_q == LAST_IDX) begin
					issuing_q <= 1'b0;
				end else begin
					issue_q <= issue_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			census_q    <= (op == ptt_pkg::OP_CENSUS);
			drop_q      <= drop_in;
			key_q       <= {address_type, address};
			now_q       <= now_ms;
			rssi_q      <= rssi;
			kind_q      <= adv_kind;
			from_name_q <= name_only_kind;
			has_dfu_q   <= has_dfu;
		end
	end

	// Table storage.
	logic [ptt_pkg::TABLE_ENTRIES-1:0] valid_q;
	logic [ptt_pkg::ENTRY_W-1:0]       ram_rdata;
	ptt_pkg::entry_t                   rd_ent, new_ent;
	logic [IW-1:0]                     wr_idx;

	ptt_ram #(
		.WIDTH (ptt_pkg::ENTRY_W),
		.DEPTH (ptt_pkg::TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx),
		.wdata (new_ent),
		.re    (ram_re),
		.raddr (issue_q),
		.rdata (ram_rdata)
	);

	assign rd_ent = ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Walk accumulators, updated once per returned entry.
	logic          match_found_q, free_found_q, min_found_q;
	logic [IW-1:0] match_idx_q, free_idx_q, min_idx_q;
	logic [TB-1:0] min_time_q;
	ptt_pkg::entry_t match_ent_q;
	logic [CW-1:0] tag_q, anchor_q, dfu_q, unk_q, stale_q, recent_q;
	logic          ent_v;
	logic [TB-1:0] ent_age;

	assign ent_v   = valid_q[rd_idx_s1];
	assign ent_age = age_of(now_q, rd_ent.last_seen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			min_found_q   <= 1'b0;
			tag_q         <= '0;
			anchor_q      <= '0;
			dfu_q         <= '0;
			unk_q         <= '0;
			stale_q       <= '0;
			recent_q      <= '0;
		end else if (accept) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			min_found_q   <= 1'b0;
			tag_q         <= '0;
			anchor_q      <= '0;
			dfu_q         <= '0;
			unk_q         <= '0;
			stale_q       <= '0;
			recent_q      <= '0;
		end else if (rd_vld_s1) begin
			if (census_q) begin
				if (ent_v) begin
					if (ent_age > win_ext(stale_window_q)) begin
						stale_q <= sat_inc(stale_q);
					end else if (ent_age <= win_ext(recent_window_q)) begin
						recent_q <= sat_inc(recent_q);
						if (rd_ent.dfu) begin
							dfu_q <= sat_inc(dfu_q);
						end
						if (rd_ent.kind == ptt_pkg::KIND_TRACKER) begin
							tag_q <= sat_inc(tag_q);
						end else if (rd_ent.kind == ptt_pkg::KIND_BEACON) begin
							anchor_q <= sat_inc(anchor_q);
						end else begin
							unk_q <= sat_inc(unk_q);
						end
					end
				end
			end else begin
				if (ent_v && (rd_ent.key == key_q) && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (!ent_v && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				// Strict compare keeps the lowest index among equal times.
				if (ent_v && (!min_found_q || (rd_ent.last_seen < min_time_q))) begin
					min_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !census_q) begin
			if (ent_v && (rd_ent.key == key_q) && !match_found_q) begin
				match_idx_q <= rd_idx_s1;
				match_ent_q <= rd_ent;
			end
			if (!ent_v && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (ent_v && (!min_found_q || (rd_ent.last_seen < min_time_q))) begin
				min_idx_q  <= rd_idx_s1;
				min_time_q <= rd_ent.last_seen;
			end
		end
	end

	// Entry update for an observation.
	ptt_pkg::entry_t old_ent;
	logic signed [8:0] rssi_diff;
	logic [8:0]        rssi_mag;
	logic              rssi_chg, kind_upd, dfu_upd, chg, rep;
	logic [1:0]        kind_n;
	logic [TB-1:0]     since;

	always_comb begin
		if (match_found_q) begin
			wr_idx  = match_idx_q;
			old_ent = match_ent_q;
		end else begin
			wr_idx  = free_found_q ? free_idx_q : min_idx_q;
			old_ent = '0;
		end
		rssi_diff = $signed({rssi_q[7], rssi_q}) - $signed({old_ent.rssi[7], old_ent.rssi});
		rssi_mag  = rssi_diff[8] ? 9'(-rssi_diff) : 9'(rssi_diff);
		rssi_chg  = (old_ent.rssi == 8'd0) || (rssi_mag >= {1'b0, rssi_threshold_q});
		kind_upd  = (kind_q != ptt_pkg::KIND_NONE) && (old_ent.kind != kind_q)
			&& (!from_name_q || (old_ent.kind == ptt_pkg::KIND_NONE));
		kind_n    = kind_upd ? kind_q : old_ent.kind;
		dfu_upd   = has_dfu_q && !old_ent.dfu;
		chg       = rssi_chg || kind_upd || dfu_upd;
		since     = age_of(now_q, old_ent.last_report);
		rep       = (kind_n != ptt_pkg::KIND_NONE) && (!old_ent.reported
			|| (chg && (since >= win_ext(change_interval_q)))
			|| (since >= win_ext(report_interval_q)));

		new_ent             = old_ent;
		new_ent.key         = key_q;
		new_ent.kind        = kind_n;
		new_ent.dfu         = old_ent.dfu || dfu_upd;
		new_ent.rssi        = rssi_q;
		new_ent.last_seen   = now_q;
		new_ent.last_report = rep ? now_q : old_ent.last_report;
		new_ent.reported    = old_ent.reported || rep;
	end

	// Output register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dropped       <= drop_q;
			slot          <= '0;
			changed       <= 1'b0;
			report        <= 1'b0;
			report_kind   <= ptt_pkg::KIND_NONE;
			report_rssi   <= '0;
			tag_count     <= '0;
			anchor_count  <= '0;
			dfu_count     <= '0;
			unknown_count <= '0;
			stale_count   <= '0;
			recent_count  <= '0;
			if (census_q) begin
				tag_count     <= tag_q;
				anchor_count  <= anchor_q;
				dfu_count     <= dfu_q;
				unknown_count <= unk_q;
				stale_count   <= stale_q;
				recent_count  <= recent_q;
			end else if (!drop_q) begin
				slot        <= slot_of(wr_idx);
				changed     <= chg;
				report      <= rep;
				report_kind <= kind_n;
				report_rssi <= rssi_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ptt_pkg::ST_IDLE, "accepted beat left block idle")
	`ASSERT_SAME(a_read_only_in_scan, rd_vld_s1, state_q == ptt_pkg::ST_SCAN, "table read returned outside a walk")
	`ASSERT_NEXT(a_write_sets_valid, ram_we, valid_q[$past(wr_idx)], "written entry not marked valid")
	`ASSERT_SAME(a_result_from_finish, $rose(out_valid_q), $past(state_q) == ptt_pkg::ST_FINISH, "result appeared without finishing an item")
	`ASSERT_ALWAYS(a_no_write_on_census, !(ram_we && census_q), "census wrote the table")
endmodule
`default_nettype wire
